[rtl/core/assert_macros.svh]
// Assertion helpers for the checker file vuht_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("%m: property failed");

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: implication failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle implication failed");

`endif

[rtl/core/vuht_pkg.sv]
`default_nettype none
package vuht_pkg;

	// Opcodes carried in the upper five bits of the first byte
	localparam logic [4:0] OP_HARD_RESET_CLIENT_V1 = 5'd1;
	localparam logic [4:0] OP_HARD_RESET_SERVER_V1 = 5'd2;
	localparam logic [4:0] OP_SOFT_RESET           = 5'd3;
	localparam logic [4:0] OP_CONTROL              = 5'd4;
	localparam logic [4:0] OP_ACK                  = 5'd5;
	localparam logic [4:0] OP_DATA_V1              = 5'd6;
	localparam logic [4:0] OP_HARD_RESET_CLIENT_V2 = 5'd7;
	localparam logic [4:0] OP_HARD_RESET_SERVER_V2 = 5'd8;
	localparam logic [4:0] OP_DATA_V2              = 5'd9;

	// Violation codes
	localparam logic [2:0] VIOL_NONE       = 3'd0;
	localparam logic [2:0] VIOL_NO_PAYLOAD = 3'd1;
	localparam logic [2:0] VIOL_BAD_START  = 3'd2;
	localparam logic [2:0] VIOL_SOFT_INIT  = 3'd3;
	localparam logic [2:0] VIOL_ACK_INIT   = 3'd4;
	localparam logic [2:0] VIOL_BAD_DATA   = 3'd5;
	localparam logic [2:0] VIOL_UNKNOWN_OP = 3'd6;

	// Event codes
	localparam logic [1:0] EV_NONE        = 2'd0;
	localparam logic [1:0] EV_HARD_RESET  = 2'd1;
	localparam logic [1:0] EV_SOFT_RESET  = 2'd2;
	localparam logic [1:0] EV_ESTABLISHED = 2'd3;

	// Hard reset kinds
	localparam logic [2:0] RK_CLIENT_V1     = 3'd0;
	localparam logic [2:0] RK_SERVER_V1     = 3'd1;
	localparam logic [2:0] RK_CLIENT_V2     = 3'd2;
	localparam logic [2:0] RK_SERVER_V2     = 3'd3;
	localparam logic [2:0] RK_PRESHARED     = 3'd4;

	// Probe test thresholds
	localparam logic [15:0] TLS_MIN_LEN = 16'd41;
	localparam logic [15:0] PSK_MIN_LEN = 16'd40;
	localparam logic [7:0]  PROBE_MAX   = 8'd1;

	typedef enum logic [2:0] {
		HS_INIT         = 3'd0,
		HS_HARD_CLIENT  = 3'd1,
		HS_HARD_SERVER  = 3'd2,
		HS_SOFT         = 3'd3,
		HS_CONTROL      = 3'd4,
		HS_DATA         = 3'd5
	} hs_t;

	typedef struct packed {
		logic [7:0]  first_byte;
		logic [15:0] packet_length;
		logic [7:0]  probe_byte_32;
		logic [7:0]  probe_byte_33;
		logic [7:0]  probe_byte_36;
		logic [7:0]  probe_byte_37;
		logic        from_originator;
	} pkt_t;

	typedef struct packed {
		logic [4:0] opcode_out;
		logic [2:0] key_id_out;
		logic       confirmed;
		logic [2:0] violation_code;
		logic [1:0] event_code;
		logic [2:0] reset_kind;
		logic       soft_reset_from_client;
		logic       tls_mode_out;
	} res_t;

	typedef struct packed {
		hs_t  hs;
		logic tls_sel;
		logic established;
		logic orig_client;
		logic first_seen;
	} trk_t;

	localparam trk_t TRK_RESET = '{
		hs:          HS_INIT,
		tls_sel:     1'b0,
		established: 1'b0,
		orig_client: 1'b1,
		first_seen:  1'b0
	};

endpackage
`default_nettype wire

[rtl/core/vuht_step.sv]
`default_nettype none
module vuht_step (
	input  var vuht_pkg::pkt_t pkt,
	input  var vuht_pkg::trk_t trk,
	output vuht_pkg::res_t     res,
	output vuht_pkg::trk_t     trk_nxt
);

	logic [4:0] op;
	logic       is_hrc;
	logic       is_hrs;
	logic       tls_ok;
	logic       psk_ok;

	assign op     = pkt.first_byte[7:3];
	assign is_hrc = (op == vuht_pkg::OP_HARD_RESET_CLIENT_V1) ||
	                (op == vuht_pkg::OP_HARD_RESET_CLIENT_V2);
	assign is_hrs = (op == vuht_pkg::OP_HARD_RESET_SERVER_V1) ||
	                (op == vuht_pkg::OP_HARD_RESET_SERVER_V2);
	assign tls_ok = (pkt.packet_length > vuht_pkg::TLS_MIN_LEN) &&
	                ((pkt.probe_byte_33 <= vuht_pkg::PROBE_MAX) ||
	                 (pkt.probe_byte_37 <= vuht_pkg::PROBE_MAX));
	assign psk_ok = (pkt.packet_length > vuht_pkg::PSK_MIN_LEN) &&
	                ((pkt.probe_byte_32 <= vuht_pkg::PROBE_MAX) ||
	                 (pkt.probe_byte_36 <= vuht_pkg::PROBE_MAX));

	always_comb begin
		trk_nxt = trk;
		res     = '0;
		if (pkt.packet_length == '0) begin
			// no payload: flag it, keep state
			res.violation_code = vuht_pkg::VIOL_NO_PAYLOAD;
			res.tls_mode_out   = trk.tls_sel;
		end else begin
			res.opcode_out = op;
			res.key_id_out = pkt.first_byte[2:0];
			if (!trk.first_seen) begin
				// server branch is reached only when the client test failed
				if (is_hrc && tls_ok) begin
					trk_nxt.tls_sel     = 1'b1;
					trk_nxt.orig_client = 1'b1;
					res.confirmed       = 1'b1;
				end else if ((is_hrc || is_hrs) && tls_ok) begin
					trk_nxt.tls_sel     = 1'b1;
					trk_nxt.orig_client = 1'b0;
					res.confirmed       = 1'b1;
				end else if (psk_ok) begin
					trk_nxt.tls_sel  = 1'b0;
					res.confirmed    = 1'b1;
				end else begin
					res.violation_code = vuht_pkg::VIOL_BAD_START;
				end
				trk_nxt.first_seen = 1'b1;
				if (!trk_nxt.tls_sel) begin
					res.event_code = vuht_pkg::EV_HARD_RESET;
					res.reset_kind = vuht_pkg::RK_PRESHARED;
				end
			end
			if (trk_nxt.tls_sel) begin
				case (op)
					vuht_pkg::OP_HARD_RESET_CLIENT_V1,
					vuht_pkg::OP_HARD_RESET_SERVER_V1,
					vuht_pkg::OP_HARD_RESET_CLIENT_V2,
					vuht_pkg::OP_HARD_RESET_SERVER_V2: begin
						trk_nxt.hs          = is_hrc ? vuht_pkg::HS_HARD_CLIENT
						                             : vuht_pkg::HS_HARD_SERVER;
						trk_nxt.established = 1'b0;
						res.event_code      = vuht_pkg::EV_HARD_RESET;
						if (op == vuht_pkg::OP_HARD_RESET_CLIENT_V1)
							res.reset_kind = vuht_pkg::RK_CLIENT_V1;
						else if (op == vuht_pkg::OP_HARD_RESET_SERVER_V1)
							res.reset_kind = vuht_pkg::RK_SERVER_V1;
						else if (op == vuht_pkg::OP_HARD_RESET_CLIENT_V2)
							res.reset_kind = vuht_pkg::RK_CLIENT_V2;
						else
							res.reset_kind = vuht_pkg::RK_SERVER_V2;
					end
					vuht_pkg::OP_SOFT_RESET: begin
						if (trk_nxt.hs == vuht_pkg::HS_INIT) begin
							res.violation_code = vuht_pkg::VIOL_SOFT_INIT;
						end else begin
							trk_nxt.hs                 = vuht_pkg::HS_SOFT;
							res.event_code             = vuht_pkg::EV_SOFT_RESET;
							res.soft_reset_from_client =
								(trk_nxt.orig_client == pkt.from_originator);
						end
					end
					vuht_pkg::OP_CONTROL: begin
						if (trk_nxt.hs != vuht_pkg::HS_INIT)
							trk_nxt.hs = vuht_pkg::HS_CONTROL;
					end
					vuht_pkg::OP_ACK: begin
						if (trk_nxt.hs == vuht_pkg::HS_INIT)
							res.violation_code = vuht_pkg::VIOL_ACK_INIT;
					end
					vuht_pkg::OP_DATA_V1,
					vuht_pkg::OP_DATA_V2: begin
						if (trk_nxt.hs == vuht_pkg::HS_CONTROL) begin
							trk_nxt.established = 1'b1;
							trk_nxt.hs          = vuht_pkg::HS_DATA;
							res.event_code      = vuht_pkg::EV_ESTABLISHED;
						end else if (!((trk_nxt.hs == vuht_pkg::HS_DATA) &&
						               trk_nxt.established)) begin
							res.violation_code = vuht_pkg::VIOL_BAD_DATA;
						end
					end
					default: begin
						res.violation_code = vuht_pkg::VIOL_UNKNOWN_OP;
					end
				endcase
			end
			res.tls_mode_out = trk_nxt.tls_sel;
		end
	end

endmodule
`default_nettype wire

[rtl/core/vpn_udp_handshake_tracker.sv]
// Tracks the handshake of a UDP tunnel from one packet summary per word and
// returns one result word per packet, in order. The first packet with a payload
// picks TLS or shared-key mode from its probe bytes (and is confirmed or flagged
// as a bad start); in TLS mode later packets walk the hard reset, soft reset,
// control and data steps, and reset, established and violation codes come out
// with the decoded opcode and key id. A packet of zero length is reported as a
// violation and leaves the state alone. Rate: one word per clock cycle in each
// direction, sustained while res_stall stays low. A word accepted on the input is
// registered in the input stage and evaluated there against the tracker state;
// when the result stage is free, its result word is registered in the result
// stage, which drives res and res_valid, and the tracker state is committed.
// The rate is set by the loop through the tracker state register.
`default_nettype none
module vpn_udp_handshake_tracker (
	input  var logic           clk,
	input  var logic           arst_n,
	input  var logic           pkt_valid,
	output logic               pkt_stall,
	input  var vuht_pkg::pkt_t pkt,
	output logic               res_valid,
	input  var logic           res_stall,
	output vuht_pkg::res_t     res
);

	// input stage
	logic           valid_s1;
	vuht_pkg::pkt_t pkt_s1;

	// result stage
	logic           valid_s2;
	vuht_pkg::res_t res_s2;

	// tracker state
	vuht_pkg::trk_t trk_q;

	vuht_pkg::res_t step_res;
	vuht_pkg::trk_t step_trk;

	logic out_free;
	logic adv_s1;

	// The result stage frees up either when empty or when its word leaves now.
	assign out_free  = !valid_s2 || !res_stall;
	assign adv_s1    = valid_s1 && out_free;
	// Hold the input side only when the input stage is full and cannot move on.
	assign pkt_stall = valid_s1 && !out_free;

	vuht_step u_step (
		.pkt     (pkt_s1),
		.trk     (trk_q),
		.res     (step_res),
		.trk_nxt (step_trk)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			trk_q    <= vuht_pkg::TRK_RESET;
		end else begin
			if (!pkt_stall)
				valid_s1 <= pkt_valid;
			if (out_free)
				valid_s2 <= valid_s1;
			// commit state only when the evaluated word moves into the result stage
			if (adv_s1)
				trk_q <= step_trk;
		end
	end

	// payload registers: no reset
	always_ff @(posedge clk) begin
		if (pkt_valid && !pkt_stall)
			pkt_s1 <= pkt;
		if (adv_s1)
			res_s2 <= step_res;
	end

	assign res_valid = valid_s2;
	assign res       = res_s2;

endmodule
`default_nettype wire

[rtl/core/vuht_checker.sv]
`default_nettype none
`include "assert_macros.svh"
module vuht_checker (
	input  var logic           clk,
	input  var logic           arst_n,
	input  var logic           pkt_stall,
	input  var logic           res_valid,
	input  var logic           res_stall,
	input  var vuht_pkg::res_t res
);

	// a stalled result word holds
	`ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && res_stall, res_valid && $stable(res))

	// input is never held back while the result side can move
	`ASSERT_IMPLIES(a_no_bubble, clk, arst_n, !(res_valid && res_stall), !pkt_stall)

	// an empty packet reports nothing but the violation and the mode
	`ASSERT_IMPLIES(a_no_payload, clk, arst_n, res_valid && res.violation_code == vuht_pkg::VIOL_NO_PAYLOAD, res.opcode_out == '0 && res.key_id_out == '0 && !res.confirmed && res.event_code == vuht_pkg::EV_NONE)

	// a confirmed first packet always carries a hard reset event and no violation
	`ASSERT_IMPLIES(a_confirm_event, clk, arst_n, res_valid && res.confirmed, res.event_code == vuht_pkg::EV_HARD_RESET && res.violation_code == vuht_pkg::VIOL_NONE)

	// soft reset side is only reported with a soft reset event
	`ASSERT_IMPLIES(a_soft_side, clk, arst_n, res_valid && res.soft_reset_from_client, res.event_code == vuht_pkg::EV_SOFT_RESET)

endmodule

bind vpn_udp_handshake_tracker vuht_checker u_vuht_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.pkt_stall (pkt_stall),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res       (res)
);
`default_nettype wire

[test/vpn_udp_handshake_tracker_tb.sv]
`timescale 1ns / 1ps

module vpn_udp_handshake_tracker_tb;

	// Opcodes with no meaning to the tracker, used to reach the unknown-opcode path
	localparam logic [4:0] OP_UNUSED_LOW   = 5'd0;
	localparam logic [4:0] OP_UNUSED_ABOVE = 5'd10;
	localparam logic [4:0] OP_UNUSED_TOP   = 5'd31;

	localparam int WORDS    = 650;
	localparam int MAX_IDLE = 12;
	localparam int SETTLE   = 10;
	// A correct run goes without a handshake only for a sender gap and a result stall,
	// each drawn up to MAX_IDLE, plus the pass through the input and result stages.
	localparam int WATCHDOG_LIMIT = 2000;

	logic clk = 1'b0;
	logic arst_n;
	logic pkt_valid;
	logic pkt_stall;
	vuht_pkg::pkt_t pkt;
	logic res_valid;
	logic res_stall;
	vuht_pkg::res_t res;

	bit calm;
	int words_sent;

	// Scoreboard: keeps its own copy of the tracker state, predicts the result
	// word of each accepted packet and checks result words against them in order.
	class handshake_scoreboard;
		vuht_pkg::hs_t  state;
		bit             tls_sel;
		bit             established;
		bit             orig_client;
		bit             first_seen;
		vuht_pkg::res_t due_q[$];
		int             failures;

		function new();
			state       = vuht_pkg::HS_INIT;
			tls_sel     = 1'b0;
			established = 1'b0;
			orig_client = 1'b1;
			first_seen  = 1'b0;
			failures    = 0;
		endfunction

		function int pending();
			return due_q.size();
		endfunction

		function void note_packet(vuht_pkg::pkt_t p);
			vuht_pkg::res_t e;
			logic [4:0]     op;
			bit             tls_ok;
			bit             psk_ok;
			bit             client_hr;
			bit             server_hr;
			e  = '0;
			op = p.first_byte[7:3];
			if (p.packet_length == 16'd0) begin
				e.violation_code = vuht_pkg::VIOL_NO_PAYLOAD;
				e.tls_mode_out   = tls_sel;
				due_q.push_back(e);
				return;
			end
			e.opcode_out = op;
			e.key_id_out = p.first_byte[2:0];
			client_hr = (op == vuht_pkg::OP_HARD_RESET_CLIENT_V1) ||
				(op == vuht_pkg::OP_HARD_RESET_CLIENT_V2);
			server_hr = (op == vuht_pkg::OP_HARD_RESET_SERVER_V1) ||
				(op == vuht_pkg::OP_HARD_RESET_SERVER_V2);
			if (!first_seen) begin
				tls_ok = (p.packet_length > vuht_pkg::TLS_MIN_LEN) &&
					(p.probe_byte_33 <= vuht_pkg::PROBE_MAX ||
					 p.probe_byte_37 <= vuht_pkg::PROBE_MAX);
				psk_ok = (p.packet_length > vuht_pkg::PSK_MIN_LEN) &&
					(p.probe_byte_32 <= vuht_pkg::PROBE_MAX ||
					 p.probe_byte_36 <= vuht_pkg::PROBE_MAX);
				if (client_hr && tls_ok) begin
					tls_sel     = 1'b1;
					e.confirmed = 1'b1;
					orig_client = 1'b1;
				end else if (server_hr && tls_ok) begin
					tls_sel     = 1'b1;
					e.confirmed = 1'b1;
					orig_client = 1'b0;
				end else if (psk_ok) begin
					tls_sel     = 1'b0;
					e.confirmed = 1'b1;
				end else begin
					e.violation_code = vuht_pkg::VIOL_BAD_START;
				end
				first_seen = 1'b1;
				if (!tls_sel) begin
					e.event_code = vuht_pkg::EV_HARD_RESET;
					e.reset_kind = vuht_pkg::RK_PRESHARED;
				end
			end
			if (tls_sel) begin
				case (op)
					vuht_pkg::OP_HARD_RESET_CLIENT_V1, vuht_pkg::OP_HARD_RESET_SERVER_V1,
					vuht_pkg::OP_HARD_RESET_CLIENT_V2, vuht_pkg::OP_HARD_RESET_SERVER_V2: begin
						state       = client_hr ? vuht_pkg::HS_HARD_CLIENT
							: vuht_pkg::HS_HARD_SERVER;
						established = 1'b0;
						e.event_code = vuht_pkg::EV_HARD_RESET;
						case (op)
							vuht_pkg::OP_HARD_RESET_CLIENT_V1:
								e.reset_kind = vuht_pkg::RK_CLIENT_V1;
							vuht_pkg::OP_HARD_RESET_SERVER_V1:
								e.reset_kind = vuht_pkg::RK_SERVER_V1;
							vuht_pkg::OP_HARD_RESET_CLIENT_V2:
								e.reset_kind = vuht_pkg::RK_CLIENT_V2;
							default:
								e.reset_kind = vuht_pkg::RK_SERVER_V2;
						endcase
					end
					vuht_pkg::OP_SOFT_RESET: begin
						if (state == vuht_pkg::HS_INIT) begin
							e.violation_code = vuht_pkg::VIOL_SOFT_INIT;
						end else begin
							state        = vuht_pkg::HS_SOFT;
							e.event_code = vuht_pkg::EV_SOFT_RESET;
							e.soft_reset_from_client = (orig_client == p.from_originator);
						end
					end
					vuht_pkg::OP_CONTROL: begin
						if (state != vuht_pkg::HS_INIT)
							state = vuht_pkg::HS_CONTROL;
					end
					vuht_pkg::OP_ACK: begin
						if (state == vuht_pkg::HS_INIT)
							e.violation_code = vuht_pkg::VIOL_ACK_INIT;
					end
					vuht_pkg::OP_DATA_V1, vuht_pkg::OP_DATA_V2: begin
						if (state == vuht_pkg::HS_CONTROL) begin
							established  = 1'b1;
							e.event_code = vuht_pkg::EV_ESTABLISHED;
							state        = vuht_pkg::HS_DATA;
						end else if (!(state == vuht_pkg::HS_DATA && established)) begin
							e.violation_code = vuht_pkg::VIOL_BAD_DATA;
						end
					end
					default: e.violation_code = vuht_pkg::VIOL_UNKNOWN_OP;
				endcase
			end
			e.tls_mode_out = tls_sel;
			due_q.push_back(e);
		endfunction

		function bit field_differs(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				return 1'b1;
			end
			return 1'b0;
		endfunction

		function void check_result(vuht_pkg::res_t r);
			vuht_pkg::res_t e;
			bit             bad;
			if (due_q.size() == 0) begin
				$error("result word %h with no packet outstanding", r);
				failures++;
				return;
			end
			e   = due_q.pop_front();
			bad = 1'b0;
			bad |= field_differs("opcode_out", 8'(e.opcode_out), 8'(r.opcode_out));
			bad |= field_differs("key_id_out", 8'(e.key_id_out), 8'(r.key_id_out));
			bad |= field_differs("confirmed", 8'(e.confirmed), 8'(r.confirmed));
			bad |= field_differs("violation_code", 8'(e.violation_code),
				8'(r.violation_code));
			bad |= field_differs("event_code", 8'(e.event_code), 8'(r.event_code));
			bad |= field_differs("reset_kind", 8'(e.reset_kind), 8'(r.reset_kind));
			bad |= field_differs("soft_reset_from_client", 8'(e.soft_reset_from_client),
				8'(r.soft_reset_from_client));
			bad |= field_differs("tls_mode_out", 8'(e.tls_mode_out), 8'(r.tls_mode_out));
			if (bad)
				failures++;
		endfunction
	endclass

	handshake_scoreboard tracker = new();

	// Opening script, played after the mode-deciding packet. Walks control and
	// data to establishment, data once established, acks, soft resets from both
	// sides, data out of order, every hard reset kind and the unknown opcodes.
	logic [4:0] opening_ops [18] = '{
		vuht_pkg::OP_CONTROL, vuht_pkg::OP_DATA_V1, vuht_pkg::OP_DATA_V2,
		vuht_pkg::OP_ACK, vuht_pkg::OP_SOFT_RESET, vuht_pkg::OP_DATA_V1,
		vuht_pkg::OP_SOFT_RESET, vuht_pkg::OP_CONTROL, vuht_pkg::OP_DATA_V2,
		vuht_pkg::OP_HARD_RESET_SERVER_V1, vuht_pkg::OP_DATA_V1,
		vuht_pkg::OP_HARD_RESET_CLIENT_V2, vuht_pkg::OP_HARD_RESET_SERVER_V2,
		vuht_pkg::OP_HARD_RESET_CLIENT_V1,
		OP_UNUSED_LOW, OP_UNUSED_ABOVE, OP_UNUSED_TOP, vuht_pkg::OP_ACK
	};

	vpn_udp_handshake_tracker u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.pkt_valid (pkt_valid),
		.pkt_stall (pkt_stall),
		.pkt       (pkt),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Draw an idle count; a calm stretch runs both sides flat out.
	function automatic int idle_cycles();
		return calm ? 0 : int'($urandom_range(0, MAX_IDLE));
	endfunction

	function automatic vuht_pkg::pkt_t make_word(logic [4:0] op, logic [2:0] kid,
			logic [15:0] len);
		vuht_pkg::pkt_t w;
		w.first_byte      = {op, kid};
		w.packet_length   = len;
		w.probe_byte_32   = 8'($urandom_range(0, 255));
		w.probe_byte_33   = 8'($urandom_range(0, 255));
		w.probe_byte_36   = 8'($urandom_range(0, 255));
		w.probe_byte_37   = 8'($urandom_range(0, 255));
		w.from_originator = 1'($urandom_range(0, 1));
		return w;
	endfunction

	function automatic logic [15:0] any_len();
		case ($urandom_range(0, 7))
			0:       return 16'd0;
			1:       return 16'hFFFF;
			2:       return 16'($urandom_range(1, 64));
			default: return 16'($urandom_range(1, 65535));
		endcase
	endfunction

	function automatic logic [15:0] payload_len();
		if ($urandom_range(0, 3) == 0)
			return 16'($urandom_range(1, 64));
		return 16'($urandom_range(1, 65535));
	endfunction

	function automatic logic [4:0] hard_reset_op();
		case ($urandom_range(0, 3))
			0:       return vuht_pkg::OP_HARD_RESET_CLIENT_V1;
			1:       return vuht_pkg::OP_HARD_RESET_SERVER_V1;
			2:       return vuht_pkg::OP_HARD_RESET_CLIENT_V2;
			default: return vuht_pkg::OP_HARD_RESET_SERVER_V2;
		endcase
	endfunction

	// The first packet with a payload fixes the mode for the rest of the run,
	// so let the seed pick it: TLS from either side, shared key reached through
	// the fall-through from a failed TLS test, or a bad start.
	function automatic vuht_pkg::pkt_t mode_packet();
		vuht_pkg::pkt_t w;
		w = make_word(vuht_pkg::OP_HARD_RESET_CLIENT_V1, 3'd0,
			vuht_pkg::TLS_MIN_LEN + 16'd1);
		w.probe_byte_32 = 8'hFF;
		w.probe_byte_33 = 8'hFF;
		w.probe_byte_36 = 8'hFF;
		w.probe_byte_37 = 8'hFF;
		case ($urandom_range(0, 11))
			0, 9: w.probe_byte_33 = vuht_pkg::PROBE_MAX;
			1, 10: begin
				w.first_byte    = {vuht_pkg::OP_HARD_RESET_CLIENT_V2, 3'd7};
				w.packet_length = 16'hFFFF;
				w.probe_byte_37 = 8'd0;
			end
			2, 11: begin
				w.first_byte    = {vuht_pkg::OP_HARD_RESET_SERVER_V1, 3'd2};
				w.probe_byte_37 = vuht_pkg::PROBE_MAX;
			end
			3: begin
				w.first_byte    = {vuht_pkg::OP_HARD_RESET_SERVER_V2, 3'd5};
				w.packet_length = 16'($urandom_range(42, 65535));
				w.probe_byte_33 = 8'd0;
			end
			4: begin
				// TLS probes pass but the length sits on the limit
				w.packet_length = vuht_pkg::TLS_MIN_LEN;
				w.probe_byte_33 = 8'd0;
				w.probe_byte_32 = 8'd0;
			end
			5: begin
				w.first_byte    = {vuht_pkg::OP_HARD_RESET_SERVER_V2, 3'd1};
				w.packet_length = 16'd100;
				w.probe_byte_33 = 8'd2;
				w.probe_byte_37 = 8'd2;
				w.probe_byte_36 = vuht_pkg::PROBE_MAX;
			end
			6: begin
				w.first_byte    = {vuht_pkg::OP_DATA_V1, 3'd5};
				w.packet_length = vuht_pkg::PSK_MIN_LEN + 16'd1;
				w.probe_byte_32 = vuht_pkg::PROBE_MAX;
			end
			7: begin
				w.first_byte    = {OP_UNUSED_LOW, 3'd0};
				w.packet_length = vuht_pkg::PSK_MIN_LEN;
				w.probe_byte_32 = 8'd0;
				w.probe_byte_33 = 8'd0;
				w.probe_byte_36 = 8'd0;
				w.probe_byte_37 = 8'd0;
			end
			default: begin
				w.probe_byte_32 = 8'd2;
				w.probe_byte_33 = 8'd2;
				w.probe_byte_36 = 8'd2;
				w.probe_byte_37 = 8'd2;
			end
		endcase
		return w;
	endfunction

	// Hold the word until it is taken; drop valid only for a drawn gap.
	task automatic send_word(vuht_pkg::pkt_t w);
		int gap;
		gap = idle_cycles();
		if (gap > 0) begin
			pkt_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pkt_valid <= 1'b1;
		pkt       <= w;
		do @(posedge clk); while (pkt_stall !== 1'b0);
		words_sent++;
	endtask

	// Lower valid and wait until every predicted result word has come back.
	task automatic drain();
		pkt_valid <= 1'b0;
		do @(posedge clk); while (tracker.pending() != 0);
	endtask

	// Note accepted words on both channels; values seen here are the ones
	// that stood before the edge.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && pkt_valid === 1'b1 && pkt_stall === 1'b0)
			tracker.note_packet(pkt);
		if (arst_n === 1'b1 && res_valid === 1'b1 && res_stall === 1'b0)
			tracker.check_result(res);
	end

	// Result side: stall for a drawn count before each word, then take it.
	initial begin : result_sink
		int n;
		res_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			n = idle_cycles();
			if (n > 0) begin
				res_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			res_stall <= 1'b0;
			do @(posedge clk); while (res_valid !== 1'b1);
		end
	end

	// End the run if the handshakes stop moving for too long.
	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		@(posedge arst_n);
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((pkt_valid === 1'b1 && pkt_stall === 1'b0) ||
					(res_valid === 1'b1 && res_stall === 1'b0))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("FAILURE");
		$finish;
	end

	initial begin : stimulus
		vuht_pkg::pkt_t seq_q[$];
		vuht_pkg::pkt_t w;
		int             choice;
		int             k;
		bit             paused;
		arst_n     <= 1'b0;
		pkt_valid  <= 1'b0;
		pkt        <= '0;
		calm       = 1'b0;
		words_sent = 0;
		paused     = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Packets without payload before the mode is known: all fields low, then all but the length high
		send_word('0);
		w = '1;
		w.packet_length = 16'd0;
		send_word(w);

		send_word(mode_packet());

		for (k = 0; k < 18; k++) begin
			w = make_word(opening_ops[k], k[0] ? 3'd7 : 3'd0,
				(k % 3 == 0) ? 16'hFFFF : payload_len());
			w.from_originator = k[1];
			send_word(w);
		end
		// No payload once the mode is set: the mode still shows
		send_word(make_word(vuht_pkg::OP_DATA_V2, 3'd3, 16'd0));
		drain();

		// Mostly whole handshakes with random content, then broken orderings,
		// noise across the whole opcode space and bursts of empty packets.
		while (words_sent < WORDS) begin
			calm = ($urandom_range(0, 5) == 0);
			seq_q.delete();
			choice = int'($urandom_range(0, 9));
			if (choice < 7) begin
				seq_q.push_back(make_word(hard_reset_op(), 3'($urandom_range(0, 7)),
					payload_len()));
				if ($urandom_range(0, 2) == 0)
					seq_q.push_back(make_word(vuht_pkg::OP_SOFT_RESET,
						3'($urandom_range(0, 7)), payload_len()));
				if ($urandom_range(0, 3) == 0)
					seq_q.push_back(make_word(vuht_pkg::OP_ACK,
						3'($urandom_range(0, 7)), payload_len()));
				seq_q.push_back(make_word(vuht_pkg::OP_CONTROL,
					3'($urandom_range(0, 7)), payload_len()));
				repeat ($urandom_range(1, 4)) begin
					seq_q.push_back(make_word(
						$urandom_range(0, 1) ? vuht_pkg::OP_DATA_V1 : vuht_pkg::OP_DATA_V2,
						3'($urandom_range(0, 7)), payload_len()));
					if ($urandom_range(0, 4) == 0)
						seq_q.push_back(make_word(vuht_pkg::OP_ACK,
							3'($urandom_range(0, 7)), payload_len()));
				end
				if ($urandom_range(0, 3) == 0) begin
					seq_q.push_back(make_word(vuht_pkg::OP_SOFT_RESET,
						3'($urandom_range(0, 7)), payload_len()));
					seq_q.push_back(make_word(vuht_pkg::OP_CONTROL,
						3'($urandom_range(0, 7)), payload_len()));
					seq_q.push_back(make_word(vuht_pkg::OP_DATA_V2,
						3'($urandom_range(0, 7)), payload_len()));
				end
			end else if (choice < 9) begin
				repeat ($urandom_range(1, 5))
					seq_q.push_back(make_word(
						5'((choice == 7)
							? $urandom_range(vuht_pkg::OP_HARD_RESET_CLIENT_V1,
								vuht_pkg::OP_DATA_V2)
							: $urandom_range(OP_UNUSED_LOW, OP_UNUSED_TOP)),
						3'($urandom_range(0, 7)), any_len()));
			end else begin
				repeat ($urandom_range(1, 3))
					seq_q.push_back(make_word(
						5'($urandom_range(OP_UNUSED_LOW, OP_UNUSED_TOP)),
						3'($urandom_range(0, 7)), 16'd0));
			end
			foreach (seq_q[i])
				send_word(seq_q[i]);
			// Once, halfway through: hold the sender until the tracker is empty
			if (!paused && words_sent >= WORDS / 2) begin
				drain();
				paused = 1'b1;
			end
		end

		drain();
		repeat (SETTLE) @(posedge clk);
		if (tracker.failures == 0 && tracker.pending() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
